### rtl/sq_pkg.sv
// Shared types and constants for the step quantizer.
// No dependencies.
package sq_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MODE_WIDTH   = 3;

    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_HALF_AWAY = 3'd0,
        MODE_TRUNC     = 3'd1,
        MODE_FLOOR     = 3'd2,
        MODE_CEIL      = 3'd3,
        MODE_AWAY      = 3'd4
    } t_round_mode;

    // per-beat control that travels alongside the datapath
    typedef struct packed {
        logic valid;
        logic neg;   // sample is negative
        logic pass;  // step <= 0, sample goes through unchanged
    } t_ctl;

endpackage

### rtl/sq_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// No dependencies.
interface sq_in_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic signed [SAMPLE_WIDTH-1:0] step_size;

    modport source (output valid, output sample_in, output step_size, input ready);
    modport sink   (input valid, input sample_in, input step_size, output ready);
endinterface

interface sq_out_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

### rtl/sq_div_cell.sv
// One restoring-division cell: develops one quotient bit per beat.
// Depends on sq_pkg.
module sq_div_cell #(
    parameter int SAMPLE_WIDTH = sq_pkg::SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  sq_pkg::t_ctl            i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_rem,
    input  logic [SAMPLE_WIDTH-1:0] i_aq,
    input  logic [SAMPLE_WIDTH-1:0] i_div,
    input  logic [SAMPLE_WIDTH-1:0] i_smp,
    output sq_pkg::t_ctl            o_ctl,
    output logic [SAMPLE_WIDTH-1:0] o_rem,
    output logic [SAMPLE_WIDTH-1:0] o_aq,
    output logic [SAMPLE_WIDTH-1:0] o_div,
    output logic [SAMPLE_WIDTH-1:0] o_smp
);
    localparam int W = SAMPLE_WIDTH;

    sq_pkg::t_ctl r_ctl;
    logic [W-1:0] r_rem, r_aq, r_div, r_smp;
    logic [W-1:0] n_rem, n_aq;
    logic [W-1:0] shifted;
    logic [W:0]   diff;
    logic         ge;

    always_comb begin
        shifted = {i_rem[W-2:0], i_aq[W-1]};
        diff    = {1'b0, shifted} - {1'b0, i_div};
        ge      = ~diff[W];
        n_rem   = ge ? diff[W-1:0] : shifted;
        n_aq    = {i_aq[W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_aq  <= n_aq;
            r_div <= i_div;
            r_smp <= i_smp;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_aq  = r_aq;
    assign o_div = r_div;
    assign o_smp = r_smp;

endmodule

### rtl/sq_round_mul.sv
// Rounding of the quotient, split multiply by the step, sign and saturation.
// Depends on sq_pkg.
module sq_round_mul #(
    parameter int SAMPLE_WIDTH = sq_pkg::SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  sq_pkg::t_round_mode     i_mode,
    input  sq_pkg::t_ctl            i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_quo,
    input  logic [SAMPLE_WIDTH-1:0] i_rem,
    input  logic [SAMPLE_WIDTH-1:0] i_div,
    input  logic [SAMPLE_WIDTH-1:0] i_smp,
    output logic                    o_valid,
    output logic [SAMPLE_WIDTH-1:0] o_result
);
    localparam int W  = SAMPLE_WIDTH;
    localparam int H  = W / 2;
    localparam int WH = W - H;
    localparam logic [2*W-1:0] LIM_POS = ((2*W)'(1) << (W-1)) - (2*W)'(1);
    localparam logic [2*W-1:0] LIM_NEG = (2*W)'(1) << (W-1);

    // round stage
    sq_pkg::t_ctl r_r_ctl;
    logic [W-1:0] r_km, r_r_div, r_r_smp;
    logic [W-1:0] n_km;
    logic         inc;
    logic         rem_nz;

    always_comb begin
        rem_nz = |i_rem;
        case (i_mode)
            sq_pkg::MODE_HALF_AWAY: inc = ({i_rem, 1'b0} >= {1'b0, i_div});
            sq_pkg::MODE_TRUNC:     inc = 1'b0;
            sq_pkg::MODE_FLOOR:     inc = i_ctl.neg & rem_nz;
            sq_pkg::MODE_CEIL:      inc = ~i_ctl.neg & rem_nz;
            sq_pkg::MODE_AWAY:      inc = rem_nz;
            default:                inc = 1'b0;
        endcase
        n_km = i_quo + W'(inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_ctl <= '0;
        end else if (i_en) begin
            r_r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_km    <= n_km;
            r_r_div <= i_div;
            r_r_smp <= i_smp;
        end
    end

    // multiply stage: two partial products on the halves of k
    sq_pkg::t_ctl    r_m_ctl;
    logic [H+W-1:0]  r_pp_lo, n_pp_lo;
    logic [WH+W-1:0] r_pp_hi, n_pp_hi;
    logic [W-1:0]    r_m_smp;

    always_comb begin
        n_pp_lo = (H+W)'(r_km[H-1:0]) * (H+W)'(r_r_div);
        n_pp_hi = (WH+W)'(r_km[W-1:H]) * (WH+W)'(r_r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
        end else if (i_en) begin
            r_m_ctl <= r_r_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_m_smp <= r_r_smp;
        end
    end

    // sum, sign and saturate into the output register
    logic           r_valid;
    logic [W-1:0]   r_result, n_result;
    logic [2*W-1:0] prod;
    logic [W-1:0]   neg_prod;

    always_comb begin
        prod     = ((2*W)'(r_pp_hi) << H) + (2*W)'(r_pp_lo);
        neg_prod = W'(0) - prod[W-1:0];
        if (r_m_ctl.pass) begin
            n_result = r_m_smp;
        end else if (r_m_ctl.neg) begin
            n_result = (prod > LIM_NEG) ? LIM_NEG[W-1:0] : neg_prod;
        end else begin
            n_result = (prod > LIM_POS) ? LIM_POS[W-1:0] : prod[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_m_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_km_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_r_ctl.valid && !r_r_ctl.pass) |-> (r_km <= LIM_NEG[W-1:0]))
        else $error("rounded quotient out of range");

    a_pass_keeps_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_m_ctl.valid && r_m_ctl.pass) |=> (r_result == $past(r_m_smp)))
        else $error("pass-through beat altered");

endmodule

### rtl/step_quantizer_unit.sv
// Step quantizer top: input prep, chain of division cells, rounding/multiply tail.
// Depends on sq_pkg, sq_if, sq_div_cell, sq_round_mul.
//
//  channel   dir  beat payload                         handshake
//  i_in      in   sample_in, step_size (signed Q15.16)  valid/ready
//  o_out     out  sample_out (signed Q15.16)            valid/ready
//  i_cfg_*   in   round_mode (3 bits)                  write enable
//
// One beat per cycle sustained while o_out takes its beats; stages in order: one prep stage,
// one division cell per quotient bit, round, multiply, output register.
// Reset is synchronous and clears beat valids and round_mode.
// A stall at o_out freezes the whole chain; i_in.ready drops only while the
// output register holds a beat that is not taken.
module step_quantizer_unit #(
    parameter int SAMPLE_WIDTH = sq_pkg::SAMPLE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sq_in_if.sink                            i_in,
    sq_out_if.source                         o_out,
    input  logic                             i_cfg_we,
    input  logic [sq_pkg::MODE_WIDTH-1:0]    i_cfg_wdata
);
    localparam int W = SAMPLE_WIDTH;

    sq_pkg::t_round_mode r_mode, n_mode;
    logic                en;
    logic                out_valid;
    logic [W-1:0]        out_result;

    always_comb begin
        if (i_cfg_wdata > sq_pkg::MODE_AWAY) begin
            n_mode = sq_pkg::MODE_AWAY;
        end else begin
            n_mode = sq_pkg::t_round_mode'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= sq_pkg::MODE_HALF_AWAY;
        end else if (i_cfg_we) begin
            r_mode <= n_mode;
        end
    end

    assign en          = ~out_valid | o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = out_valid;
    assign o_out.sample_out = out_result;

    // prep stage: magnitude of sample, pass-through flag
    sq_pkg::t_ctl r_p_ctl, n_p_ctl;
    logic [W-1:0] r_p_abs, r_p_div, r_p_smp;
    logic [W-1:0] n_p_abs;

    always_comb begin
        n_p_ctl.valid = i_in.valid;
        n_p_ctl.neg   = i_in.sample_in[W-1];
        n_p_ctl.pass  = i_in.step_size[W-1] | ~(|i_in.step_size);
        n_p_abs       = i_in.sample_in[W-1] ? (W'(0) - W'(i_in.sample_in))
                                            : W'(i_in.sample_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else if (en) begin
            r_p_ctl <= n_p_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_abs <= n_p_abs;
            r_p_div <= W'(i_in.step_size);
            r_p_smp <= W'(i_in.sample_in);
        end
    end

    // division chain
    sq_pkg::t_ctl c_ctl [W+1];
    logic [W-1:0] c_rem [W+1];
    logic [W-1:0] c_aq  [W+1];
    logic [W-1:0] c_div [W+1];
    logic [W-1:0] c_smp [W+1];

    assign c_ctl[0] = r_p_ctl;
    assign c_rem[0] = '0;
    assign c_aq[0]  = r_p_abs;
    assign c_div[0] = r_p_div;
    assign c_smp[0] = r_p_smp;

    for (genvar g = 0; g < W; g++) begin : g_cell
        sq_div_cell #(
            .SAMPLE_WIDTH(W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_aq    (c_aq[g]),
            .i_div   (c_div[g]),
            .i_smp   (c_smp[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_aq    (c_aq[g+1]),
            .o_div   (c_div[g+1]),
            .o_smp   (c_smp[g+1])
        );
    end

    sq_round_mul #(
        .SAMPLE_WIDTH(W)
    ) u_round_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_mode   (r_mode),
        .i_ctl    (c_ctl[W]),
        .i_quo    (c_aq[W]),
        .i_rem    (c_rem[W]),
        .i_div    (c_div[W]),
        .i_smp    (c_smp[W]),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    a_mode_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= sq_pkg::MODE_AWAY)
        else $error("round mode above legal range");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_ctl[W].valid && !c_ctl[W].pass) |-> (c_rem[W] < c_div[W]))
        else $error("division remainder not below step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && !r_p_ctl.valid)
        else $error("beats survive reset");

endmodule

### dv/step_quantizer_unit_test.sv
// Self-checking testbench for step_quantizer_unit: random and directed sample/step beats
// under every rounding mode, checked against an in-bench quantizer with random idling.
// Depends on sq_pkg, sq_if and step_quantizer_unit.
module step_quantizer_unit_test;

    localparam int SW = sq_pkg::SAMPLE_WIDTH;
    localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic signed [SW-1:0] smp;
        logic signed [SW-1:0] stp;
    } t_quant_req;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sq_pkg::MODE_WIDTH-1:0] i_cfg_wdata;

    sq_in_if  #(.SAMPLE_WIDTH(SW)) in_bus ();
    sq_out_if #(.SAMPLE_WIDTH(SW)) out_bus ();

    step_quantizer_unit #(.SAMPLE_WIDTH(SW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_quant_req           pending_beats[$];
    logic signed [SW-1:0] quant_expect[$];
    sq_pkg::t_round_mode  mode_now = sq_pkg::MODE_HALF_AWAY;
    int                   queued_cnt = 0;
    int                   results_seen = 0;
    int                   mismatch_cnt = 0;
    int                   in_gap_max = 0;
    int                   out_gap_max = 0;
    int                   in_wait = 0;
    int                   out_wait = 0;
    logic                 pressure_go = 1'b0;
    logic                 hold_off = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic signed [SW-1:0] quantize_sample(
        input logic signed [SW-1:0] smp,
        input logic signed [SW-1:0] stp,
        input sq_pkg::t_round_mode  md
    );
        longint              s;
        longint              t;
        longint              q;
        longint              r;
        longint              mag;
        longint              p;
        longint              hi;
        sq_pkg::t_round_mode eff;
        s   = smp;
        t   = stp;
        hi  = (longint'(1) <<< (SW - 1)) - 1;
        if (t <= 0)
            return smp;
        q   = s / t;
        r   = s - q * t;
        eff = md;
        if (md == sq_pkg::MODE_AWAY)
            eff = (s > 0) ? sq_pkg::MODE_CEIL : sq_pkg::MODE_FLOOR;
        case (eff)
            sq_pkg::MODE_HALF_AWAY: begin
                mag = (r < 0) ? -r : r;
                if (2 * mag >= t)
                    q += (s < 0) ? -1 : 1;
            end
            sq_pkg::MODE_FLOOR: begin
                if (r < 0)
                    q -= 1;
            end
            sq_pkg::MODE_CEIL: begin
                if (r > 0)
                    q += 1;
            end
            default: begin
            end
        endcase
        p = q * t;
        if (p > hi)
            p = hi;
        else if (p < -hi - 1)
            p = -hi - 1;
        return p[SW-1:0];
    endfunction

    function automatic t_quant_req rand_req();
        t_quant_req req;
        longint     h;
        longint     kmax;
        longint     k;
        req.smp = $urandom;
        req.stp = $urandom;
        case ($urandom_range(0, 9))
            0: begin
            end
            1: req.stp = $urandom_range(0, 3) == 0 ? '0 : {1'b1, req.stp[SW-2:0]};
            2, 3, 4: req.stp = $urandom_range(1, 1023);
            5: req.stp = $urandom_range(1, 64) << 14;
            6: begin
                // exact ties between two multiples
                h       = $urandom_range(1, 1 << 20);
                req.stp = SW'(2 * h);
                kmax    = 64'h7fff_ffff / (2 * h) - 1;
                k       = longint'($urandom_range(0, 32'(2 * kmax))) - kmax;
                if (k < 0 || (k == 0 && $urandom_range(0, 1) == 1))
                    req.smp = SW'(k * 2 * h - h);
                else
                    req.smp = SW'(k * 2 * h + h);
            end
            7: begin
                req.stp = $urandom_range(1, 1 << 24);
                kmax    = 64'h7fff_ffff / longint'(req.stp);
                k       = longint'($urandom_range(0, 32'(2 * kmax))) - kmax;
                req.smp = SW'(k * longint'(req.stp));
            end
            8: begin
                case ($urandom_range(0, 6))
                    0: req.smp = SMP_MAX;
                    1: req.smp = SMP_MIN;
                    2: req.smp = SMP_MAX - 1;
                    3: req.smp = SMP_MIN + 1;
                    4: req.smp = '0;
                    5: req.smp = 1;
                    default: req.smp = -1;
                endcase
                case ($urandom_range(0, 4))
                    0: req.stp = 1;
                    1: req.stp = SMP_MAX;
                    2: req.stp = 2;
                    3: req.stp = 32'h4000_0000;
                    default: req.stp = $urandom_range(1, 32'h7fff_ffff);
                endcase
            end
            default: req.stp = $urandom_range(32'h0100_0000, 32'h7fff_ffff);
        endcase
        return req;
    endfunction

    task automatic queue_req(input logic signed [SW-1:0] smp, input logic signed [SW-1:0] stp);
        t_quant_req req;
        req.smp = smp;
        req.stp = stp;
        pending_beats.push_back(req);
        queued_cnt++;
    endtask

    task automatic queue_directed();
        queue_req(0, 1);
        queue_req(SMP_MAX, 1);
        queue_req(SMP_MIN, 1);
        queue_req(SMP_MAX, 32'h4000_0000);
        queue_req(SMP_MIN, SMP_MAX);
        queue_req(SMP_MIN, 32'h4000_0000);
        queue_req(32'h1234_5678, 0);
        queue_req(32'h1234_5678, -1);
        queue_req(-32'sh0123_4567, SMP_MIN);
        queue_req(32'h0001_8000, 32'h0001_0000);
        queue_req(-32'sh0001_8000, 32'h0001_0000);
        queue_req(32'h0001_7fff, 32'h0001_0000);
        queue_req(-32'sh0002_8001, 32'h0001_0000);
        queue_req(SMP_MAX, SMP_MAX);
        queue_req(SMP_MIN + 1, SMP_MAX);
        queue_req(5, 3);
        queue_req(-5, 3);
        queue_req(-1, 2);
        queue_req(1, SMP_MAX);
    endtask

    // cfg_val < 0 keeps the current mode (reset value on the first pass)
    task automatic run_phase(input int cfg_val, input int n_rand, input int gin,
                             input int gout, input bit pressure);
        t_quant_req req;
        if (cfg_val >= 0) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= cfg_val[sq_pkg::MODE_WIDTH-1:0];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            mode_now = (cfg_val > int'(sq_pkg::MODE_AWAY)) ? sq_pkg::MODE_AWAY
                                                            : sq_pkg::t_round_mode'(cfg_val);
        end
        @(negedge i_clk);
        in_gap_max  = gin;
        out_gap_max = gout;
        if (pressure)
            pressure_go = 1'b1;
        queue_directed();
        repeat (n_rand) begin
            req = rand_req();
            queue_req(req.smp, req.stp);
        end
        while (results_seen < queued_cnt)
            @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                quant_expect.push_back(quantize_sample(in_bus.sample_in, in_bus.step_size,
                                                       mode_now));
                in_wait = $urandom_range(0, in_gap_max);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (in_wait > 0) begin
                    in_wait--;
                    in_bus.valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    t_quant_req req;
                    req = pending_beats.pop_front();
                    in_bus.sample_in <= req.smp;
                    in_bus.step_size <= req.stp;
                    in_bus.valid     <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (quant_expect.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: sample_out=%h", out_bus.sample_out);
                end else begin
                    logic signed [SW-1:0] want;
                    want = quant_expect.pop_front();
                    results_seen++;
                    if (out_bus.sample_out !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("sample_out mismatch on beat %0d: expected %h, got %h",
                                     results_seen, want, out_bus.sample_out);
                    end
                end
                out_wait = $urandom_range(0, out_gap_max);
            end else if (out_wait > 0) begin
                out_wait--;
            end
            out_bus.ready <= !hold_off && out_wait == 0;
        end
    end

    // long output stall so the pipe fills and backs up into the input
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("step_quantizer_unit test failed");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_bus.valid      = 1'b0;
        in_bus.sample_in  = '0;
        in_bus.step_size  = '0;
        out_bus.ready     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_phase(-1, 30, 12, 12, 1'b0);
        run_phase(int'(sq_pkg::MODE_TRUNC), 30, 0, 0, 1'b0);
        run_phase(int'(sq_pkg::MODE_FLOOR), 30, 3, 12, 1'b0);
        run_phase(int'(sq_pkg::MODE_CEIL), 60, 0, 4, 1'b1);
        run_phase(int'(sq_pkg::MODE_AWAY), 30, 12, 0, 1'b0);
        run_phase(5, 20, 6, 6, 1'b0);
        run_phase(6, 20, 0, 12, 1'b0);
        run_phase(7, 20, 12, 3, 1'b0);
        run_phase(int'(sq_pkg::MODE_HALF_AWAY), 30, 2, 2, 1'b0);
        run_phase($urandom_range(0, 7), 40, $urandom_range(0, 12), $urandom_range(0, 12), 1'b0);

        repeat (SW + 4) @(posedge i_clk);
        if (mismatch_cnt == 0 && quant_expect.size() == 0)
            $display("step_quantizer_unit test passed");
        else
            $display("step_quantizer_unit test failed");
        $finish;
    end

endmodule
